// ----- hw/rtl/waypoint_heading_steering_assert.svh -----
// ----------------------------------------------------------------------------
// Waypoint heading steering assertion macros
// Concurrent assertion macros shared by the steering block.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_HEADING_STEERING_ASSERT_SVH
`define WAYPOINT_HEADING_STEERING_ASSERT_SVH

// Checked property, disabled while reset is held.
`define WHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define WHS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/whs_pkg.sv -----
// ----------------------------------------------------------------------------
// Waypoint heading steering package
// Constants, types and the arctangent table of the bearing CORDIC.
// ----------------------------------------------------------------------------
package whs_pkg;

    localparam int MAX_WAYPOINTS = 16;
    localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
    localparam int CORDIC_STEPS  = 14;
    localparam int STEP_W        = $clog2(CORDIC_STEPS);

    localparam int CX_W = 36;
    localparam int CZ_W = 28;

    localparam logic signed [CZ_W-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [17:0] ANG_PI    = 18'sd25736;
    localparam logic signed [17:0] ANG_2PI   = 18'sd51472;
    localparam logic signed [17:0] ANG_PI4   = 18'sd6434;

    localparam logic [31:0] START_X_RST   = 32'd0;
    localparam logic [31:0] START_Y_RST   = 32'd0;
    localparam logic [4:0]  COUNT_RST     = 5'd1;
    localparam logic [30:0] THRESHOLD_RST = 31'd6554;
    localparam logic [30:0] CRUISE_RST    = 31'd327680;

    typedef enum logic [2:0] {
        REG_START_X   = 3'd0,
        REG_START_Y   = 3'd1,
        REG_COUNT     = 3'd2,
        REG_THRESHOLD = 3'd3,
        REG_CRUISE    = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_INIT,
        ST_ITER,
        ST_FIN
    } t_state;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Arctangent of 2^-i in units of 2^-24 rad.
    function automatic logic signed [CZ_W-1:0] atan_q24(input logic [4:0] i);
        logic signed [CZ_W-1:0] r;
        begin
            unique case (i)
                5'd0:  r = 28'sd13176795;
                5'd1:  r = 28'sd7778716;
                5'd2:  r = 28'sd4110060;
                5'd3:  r = 28'sd2086331;
                5'd4:  r = 28'sd1047214;
                5'd5:  r = 28'sd524117;
                5'd6:  r = 28'sd262123;
                5'd7:  r = 28'sd131069;
                5'd8:  r = 28'sd65536;
                5'd9:  r = 28'sd32768;
                5'd10: r = 28'sd16384;
                5'd11: r = 28'sd8192;
                5'd12: r = 28'sd4096;
                5'd13: r = 28'sd2048;
                5'd14: r = 28'sd1024;
                5'd15: r = 28'sd512;
                5'd16: r = 28'sd256;
                5'd17: r = 28'sd128;
                5'd18: r = 28'sd64;
                5'd19: r = 28'sd32;
                5'd20: r = 28'sd16;
                5'd21: r = 28'sd8;
                5'd22: r = 28'sd4;
                5'd23: r = 28'sd2;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- hw/rtl/waypoint_heading_steering.sv -----
// ----------------------------------------------------------------------------
// Waypoint heading steering
// Proportional waypoint-following guidance with a waypoint table in memory.
// ----------------------------------------------------------------------------
// A load transaction stores start plus offset, saturated, into a slot of
// the waypoint memory. A step transaction reads the memory, forms the
// differences, prerotates, runs the iterations of the shared vectoring
// CORDIC, and then wraps, clamps and registers the result. The distance
// test shares one multiplier over the first CORDIC iterations. A finished
// result waits in the output register while the next transaction is
// accepted. Table entries read before they are written give undefined
// results.
module waypoint_heading_steering (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [3:0]  i_waypoint_slot,
    input  logic signed [31:0] i_offset_x,
    input  logic signed [31:0] i_offset_y,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_heading,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [30:0] o_forward_speed,
    output logic signed [13:0] o_turn_rate,
    output logic        o_reached,
    output logic [3:0]  o_next_waypoint
);
    `include "waypoint_heading_steering_assert.svh"

    localparam int IW = whs_pkg::IDX_W;
    localparam int XW = whs_pkg::CX_W;
    localparam int ZW = whs_pkg::CZ_W;
    localparam int SW = whs_pkg::STEP_W;

    // Configuration.
    logic signed [31:0] r_start_x, r_start_y;
    logic [4:0]  r_count;
    logic [30:0] r_thr, r_cruise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= whs_pkg::START_X_RST;
            r_start_y <= whs_pkg::START_Y_RST;
            r_count   <= whs_pkg::COUNT_RST;
            r_thr     <= whs_pkg::THRESHOLD_RST;
            r_cruise  <= whs_pkg::CRUISE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                whs_pkg::REG_START_X:   r_start_x <= i_cfg_data;
                whs_pkg::REG_START_Y:   r_start_y <= i_cfg_data;
                whs_pkg::REG_COUNT:     r_count   <= i_cfg_data[4:0];
                whs_pkg::REG_THRESHOLD: r_thr     <= i_cfg_data[30:0];
                whs_pkg::REG_CRUISE:    r_cruise  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    whs_pkg::t_state r_state, n_state;
    logic in_acc, out_acc;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_state != whs_pkg::ST_IDLE);

    // Waypoint memory: x in the upper half, y in the lower half.
    logic [63:0] r_mem [whs_pkg::MAX_WAYPOINTS];
    logic [63:0] r_rd_data;
    logic [IW-1:0] r_idx;

    logic signed [32:0] sum_x, sum_y;
    logic [31:0] sat_x, sat_y;
    logic slot_ok, mem_we;
    assign sum_x = 33'(r_start_x) + 33'(i_offset_x);
    assign sum_y = 33'(r_start_y) + 33'(i_offset_y);
    assign sat_x = (sum_x[32] != sum_x[31]) ? {sum_x[32], {31{~sum_x[32]}}} : sum_x[31:0];
    assign sat_y = (sum_y[32] != sum_y[31]) ? {sum_y[32], {31{~sum_y[32]}}} : sum_y[31:0];
    assign slot_ok = {1'b0, i_waypoint_slot} < 5'(whs_pkg::MAX_WAYPOINTS);
    assign mem_we  = in_acc && (i_action == whs_pkg::ACT_LOAD) && slot_ok;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_waypoint_slot[IW-1:0]] <= {sat_x, sat_y};
        end
        r_rd_data <= r_mem[r_idx];
    end

    // Datapath registers.
    logic signed [31:0] r_px, r_py;
    logic signed [15:0] r_head;
    logic signed [32:0] r_dx, r_dy;
    logic signed [XW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic r_zero, r_near, r_reach;
    logic [30:0] r_ax, r_ay;
    logic [61:0] r_sq;
    logic [62:0] r_d2;
    logic [SW-1:0] r_step;

    logic signed [32:0] ax_full, ay_full;
    assign ax_full = r_dx[32] ? -r_dx : r_dx;
    assign ay_full = r_dy[32] ? -r_dy : r_dy;

    logic signed [XW-1:0] xs, ys;
    assign xs = r_cx >>> r_step;
    assign ys = r_cy >>> r_step;

    // One shared multiplier for the distance test.
    logic [30:0] mul_op;
    logic [61:0] mul_p;
    always_comb begin
        unique case (r_step)
            SW'(0):  mul_op = r_ax;
            SW'(1):  mul_op = r_ay;
            default: mul_op = r_thr;
        endcase
    end
    assign mul_p = mul_op * mul_op;

    // Final angle arithmetic.
    logic signed [ZW-1:0] z_rnd;
    logic signed [17:0] bearing, err_raw, err_wrap, err_clamp;
    logic [IW:0] idx_inc;
    logic [IW-1:0] idx_next;
    assign z_rnd   = r_cz + ZW'(2048);
    assign bearing = r_zero ? 18'sd0 : 18'($signed(z_rnd[ZW-1:11]));
    assign err_raw = bearing - 18'(r_head);
    always_comb begin
        if (err_raw > whs_pkg::ANG_PI) begin
            err_wrap = err_raw - whs_pkg::ANG_2PI;
        end else if (err_raw < -whs_pkg::ANG_PI) begin
            err_wrap = err_raw + whs_pkg::ANG_2PI;
        end else begin
            err_wrap = err_raw;
        end
        if (err_wrap > whs_pkg::ANG_PI4) begin
            err_clamp = whs_pkg::ANG_PI4;
        end else if (err_wrap < -whs_pkg::ANG_PI4) begin
            err_clamp = -whs_pkg::ANG_PI4;
        end else begin
            err_clamp = err_wrap;
        end
    end
    assign idx_inc  = {1'b0, r_idx} + (IW+1)'(1);
    assign idx_next = (5'(idx_inc) >= r_count
                       || 9'(idx_inc) >= 9'(whs_pkg::MAX_WAYPOINTS)) ? '0 : idx_inc[IW-1:0];

    logic fin_go;
    assign fin_go = (r_state == whs_pkg::ST_FIN) && (!o_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            whs_pkg::ST_IDLE: begin
                if (in_acc && i_action == whs_pkg::ACT_STEP) begin
                    n_state = whs_pkg::ST_READ;
                end
            end
            whs_pkg::ST_READ: n_state = whs_pkg::ST_INIT;
            whs_pkg::ST_INIT: n_state = whs_pkg::ST_ITER;
            whs_pkg::ST_ITER: begin
                if (r_step == SW'(whs_pkg::CORDIC_STEPS - 1)) begin
                    n_state = whs_pkg::ST_FIN;
                end
            end
            whs_pkg::ST_FIN: begin
                if (fin_go) begin
                    n_state = whs_pkg::ST_IDLE;
                end
            end
            default: n_state = whs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= whs_pkg::ST_IDLE;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_go) begin
                o_valid <= 1'b1;
                if (r_reach) begin
                    r_idx <= idx_next;
                end
            end else if (out_acc) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_head <= i_heading;
        end
        if (r_state == whs_pkg::ST_READ) begin
            r_dx <= 33'($signed(r_rd_data[63:32])) - 33'(r_px);
            r_dy <= 33'($signed(r_rd_data[31:0])) - 33'(r_py);
        end
        if (r_state == whs_pkg::ST_INIT) begin
            r_step <= '0;
            r_zero <= (r_dx == '0) && (r_dy == '0);
            r_near <= (ax_full < 33'(r_thr)) && (ay_full < 33'(r_thr));
            r_ax   <= ax_full[30:0];
            r_ay   <= ay_full[30:0];
            // Rotate into the right half plane first.
            if (!r_dx[32]) begin
                r_cx <= XW'(r_dx);
                r_cy <= XW'(r_dy);
                r_cz <= '0;
            end else if (!r_dy[32]) begin
                r_cx <= XW'(r_dy);
                r_cy <= -XW'(r_dx);
                r_cz <= whs_pkg::HALF_PI_Q24;
            end else begin
                r_cx <= -XW'(r_dy);
                r_cy <= XW'(r_dx);
                r_cz <= -whs_pkg::HALF_PI_Q24;
            end
        end
        if (r_state == whs_pkg::ST_ITER) begin
            r_step <= r_step + SW'(1);
            if (!r_cy[XW-1]) begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + whs_pkg::atan_q24(5'(r_step));
            end else begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - whs_pkg::atan_q24(5'(r_step));
            end
            unique case (r_step)
                SW'(0): r_sq <= mul_p;
                SW'(1): begin
                    r_d2 <= 63'(r_sq);
                    r_sq <= mul_p;
                end
                SW'(2): begin
                    r_d2 <= r_d2 + 63'(r_sq);
                    r_sq <= mul_p;
                end
                SW'(3): r_reach <= r_near && (r_d2 < 63'(r_sq));
                default: ;
            endcase
        end
        if (fin_go) begin
            o_forward_speed <= r_cruise;
            o_turn_rate     <= err_clamp[13:0];
            o_reached       <= r_reach;
            o_next_waypoint <= 4'(r_reach ? idx_next : r_idx);
        end
    end

    `WHS_ASSERT(a_step_reads, in_acc && i_action == whs_pkg::ACT_STEP |=> r_state == whs_pkg::ST_READ, "step did not start a read")
    `WHS_ASSERT(a_load_short, in_acc && i_action == whs_pkg::ACT_LOAD |=> r_state == whs_pkg::ST_IDLE, "load did not finish in one cycle")
    `WHS_ASSERT(a_iter_end, r_state == whs_pkg::ST_ITER && r_step == SW'(whs_pkg::CORDIC_STEPS - 1) |=> r_state == whs_pkg::ST_FIN, "CORDIC overran")
    `WHS_ASSERT(a_result_src, $rose(o_valid) |-> $past(r_state) == whs_pkg::ST_FIN, "result without a finished step")
    `WHS_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> r_state == whs_pkg::ST_IDLE && !o_valid, "reset did not clear control")

endmodule
